[hdl/darpc_pkg.sv]
// Shared constants, register indexes and pipeline control type for the dual-axis ramp controller.
package darpc_pkg;

  localparam int GAIN_BITS      = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [GAIN_BITS-1:0]      gain_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_LIN_RAMP_STEP = 3'd0;
  localparam cfg_index_t REG_ANG_RAMP_STEP = 3'd1;
  localparam cfg_index_t REG_LIN_GAIN_P    = 3'd2;
  localparam cfg_index_t REG_LIN_GAIN_I    = 3'd3;
  localparam cfg_index_t REG_LIN_GAIN_K    = 3'd4;
  localparam cfg_index_t REG_ANG_GAIN_P    = 3'd5;
  localparam cfg_index_t REG_ANG_GAIN_I    = 3'd6;
  localparam cfg_index_t REG_ANG_GAIN_K    = 3'd7;

  localparam gain_t LIN_GAIN_P_RST = 16'd52429;
  localparam gain_t LIN_GAIN_I_RST = 16'd197;
  localparam gain_t LIN_GAIN_K_RST = 16'd6554;
  localparam gain_t ANG_GAIN_P_RST = 16'd6554;
  localparam gain_t ANG_GAIN_I_RST = 16'd66;
  localparam gain_t ANG_GAIN_K_RST = 16'd6554;

  typedef struct packed {
    logic ld_ramp;
    logic ld_err;
    logic ld_mul;
    logic ld_out;
  } pipe_ctl_t;

endpackage

[hdl/darpc_axis.sv]
// One axis datapath: target load, setpoint ramp, error sum, gain products and saturated effort.
module darpc_axis import darpc_pkg::*; #(
  parameter int VALUE_BITS = 24,
  parameter int SUM_BITS   = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pipe_ctl_t                    ctl,
  input  logic [VALUE_BITS-2:0]        ramp_step,
  input  gain_t                        gain_p,
  input  gain_t                        gain_i,
  input  gain_t                        gain_k,
  input  logic signed [VALUE_BITS-1:0] measured,
  input  logic                         load,
  input  logic signed [VALUE_BITS-1:0] target,
  output logic signed [VALUE_BITS-1:0] setpoint,
  output logic signed [VALUE_BITS-1:0] effort
);

  localparam int EW = VALUE_BITS + 1;
  localparam int SW = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;
  localparam int PW = EW + GAIN_BITS + 1;
  localparam int IW = SUM_BITS + GAIN_BITS + 1;
  localparam int TW = ((IW > PW) ? IW : PW) + 2;

  localparam logic signed [SW-1:0] SUM_MAX = {{(SW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [TW-1:0] EFF_MAX = {{(TW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [TW-1:0] EFF_MIN = ~EFF_MAX;
  localparam logic signed [TW-1:0] ROUND_C =
    {{(TW-GAIN_BITS){1'b0}}, 1'b1, {(GAIN_BITS-1){1'b0}}};

  logic signed [VALUE_BITS-1:0] tgt_now_r, tgt_before_r, sp_r;
  logic signed [VALUE_BITS-1:0] tnow_c, tbef_c, sp_nxt;
  logic signed [EW-1:0]         sp_up_c, sp_dn_c, tnow_ext_c, step_ext_c;

  logic signed [VALUE_BITS-1:0] s1_meas_r, s1_sp_r;

  logic signed [EW-1:0]         last_err_r, err_c;
  logic signed [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic signed [SW-1:0]         sum_c;
  logic signed [EW-1:0]         s2_err_r, s2_prev_r;
  logic signed [SUM_BITS-1:0]   s2_sum_r;
  logic signed [VALUE_BITS-1:0] s2_sp_r;

  logic signed [PW-1:0]         p_c, k_c, s3_p_r, s3_k_r;
  logic signed [IW-1:0]         i_c, s3_i_r;
  logic signed [VALUE_BITS-1:0] s3_sp_r;

  logic signed [TW-1:0]         acc_c, tot_c;
  logic signed [VALUE_BITS-1:0] eff_c;
  logic signed [VALUE_BITS-1:0] setpoint_r, effort_r;

  always_comb begin
    tnow_c     = load ? target : tgt_now_r;
    tbef_c     = load ? tgt_now_r : tgt_before_r;
    tnow_ext_c = EW'(tnow_c);
    step_ext_c = $signed({2'b00, ramp_step});
    sp_up_c    = EW'(sp_r) + step_ext_c;
    sp_dn_c    = EW'(sp_r) - step_ext_c;
    if (tbef_c < tnow_c) begin
      sp_nxt = (sp_up_c > tnow_ext_c) ? tnow_c : sp_up_c[VALUE_BITS-1:0];
    end else begin
      sp_nxt = (sp_dn_c < tnow_ext_c) ? tnow_c : sp_dn_c[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    err_c = EW'(s1_meas_r) - EW'(s1_sp_r);
    sum_c = SW'(sum_r) + SW'(err_c);
    if (sum_c > SUM_MAX) begin
      sum_nxt = SUM_MAX[SUM_BITS-1:0];
    end else if (sum_c < SUM_MIN) begin
      sum_nxt = SUM_MIN[SUM_BITS-1:0];
    end else begin
      sum_nxt = sum_c[SUM_BITS-1:0];
    end
  end

  always_comb begin
    p_c = PW'($signed({1'b0, gain_p})) * PW'(s2_err_r);
    k_c = PW'($signed({1'b0, gain_k})) * PW'(s2_prev_r);
    i_c = IW'($signed({1'b0, gain_i})) * IW'(s2_sum_r);
  end

  always_comb begin
    acc_c = TW'(s3_p_r) + TW'(s3_k_r) + TW'(s3_i_r) + ROUND_C;
    tot_c = acc_c >>> GAIN_BITS;
    if (tot_c > EFF_MAX) begin
      eff_c = EFF_MAX[VALUE_BITS-1:0];
    end else if (tot_c < EFF_MIN) begin
      eff_c = EFF_MIN[VALUE_BITS-1:0];
    end else begin
      eff_c = tot_c[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_now_r    <= '0;
      tgt_before_r <= '0;
      sp_r         <= '0;
      last_err_r   <= '0;
      sum_r        <= '0;
    end else begin
      if (ctl.ld_ramp) begin
        tgt_now_r    <= tnow_c;
        tgt_before_r <= tbef_c;
        sp_r         <= sp_nxt;
      end
      if (ctl.ld_err) begin
        last_err_r <= err_c;
        sum_r      <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_ramp) begin
      s1_meas_r <= measured;
      s1_sp_r   <= sp_nxt;
    end
    if (ctl.ld_err) begin
      s2_err_r  <= err_c;
      s2_prev_r <= last_err_r;
      s2_sum_r  <= sum_nxt;
      s2_sp_r   <= s1_sp_r;
    end
    if (ctl.ld_mul) begin
      s3_p_r  <= p_c;
      s3_k_r  <= k_c;
      s3_i_r  <= i_c;
      s3_sp_r <= s2_sp_r;
    end
    if (ctl.ld_out) begin
      setpoint_r <= s3_sp_r;
      effort_r   <= eff_c;
    end
  end

  assign setpoint = setpoint_r;
  assign effort   = effort_r;

endmodule

[hdl/dual_axis_ramp_pid_controller.sv]
// Top level of the dual-axis ramp controller: handshakes, configuration registers and both axes.
// The block takes one beat per clock cycle while in_ready is high and returns results in order,
// one result per input beat. The four-stage pipeline is set by its loops: the target load and
// setpoint ramp close in the cycle of acceptance, the error and saturating error sum close in
// the second stage, then the gain products and the rounded, saturated effort each take a stage.
// Every stage holds its beat only while the one after it is full and stalled, so input beats
// are accepted while a result waits at the output until the stages fill. Configuration
// writes are taken in any cycle and should be made only while no beat is in flight.
module dual_axis_ramp_pid_controller import darpc_pkg::*; #(
  parameter int VALUE_BITS = 24,
  parameter int SUM_BITS   = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_measured_velocity,
  input  logic signed [VALUE_BITS-1:0] in_measured_angular_rate,
  input  logic                         in_load_linear_target,
  input  logic signed [VALUE_BITS-1:0] in_linear_target,
  input  logic                         in_load_angular_target,
  input  logic signed [VALUE_BITS-1:0] in_angular_target,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] out_linear_setpoint,
  output logic signed [VALUE_BITS-1:0] out_angular_setpoint,
  output logic signed [VALUE_BITS-1:0] out_linear_effort,
  output logic signed [VALUE_BITS-1:0] out_angular_effort,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  cfg_index_t                   cfg_index,
  input  logic [VALUE_BITS-1:0]        cfg_data
);

  logic [VALUE_BITS-2:0] lin_step_r, ang_step_r;
  gain_t                 lin_gp_r, lin_gi_r, lin_gk_r;
  gain_t                 ang_gp_r, ang_gi_r, ang_gk_r;

  logic      v1_r, v2_r, v3_r, out_valid_r;
  logic      rdy_out, rdy3, rdy2, rdy1;
  pipe_ctl_t ctl;

  always_comb begin
    rdy_out     = !out_valid_r || out_ready;
    rdy3        = !v3_r || rdy_out;
    rdy2        = !v2_r || rdy3;
    rdy1        = !v1_r || rdy2;
    ctl.ld_out  = v3_r && rdy_out;
    ctl.ld_mul  = v2_r && rdy3;
    ctl.ld_err  = v1_r && rdy2;
    ctl.ld_ramp = in_valid && rdy1;
  end

  assign in_ready  = rdy1;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.ld_ramp) begin
        v1_r <= 1'b1;
      end else if (ctl.ld_err) begin
        v1_r <= 1'b0;
      end
      if (ctl.ld_err) begin
        v2_r <= 1'b1;
      end else if (ctl.ld_mul) begin
        v2_r <= 1'b0;
      end
      if (ctl.ld_mul) begin
        v3_r <= 1'b1;
      end else if (ctl.ld_out) begin
        v3_r <= 1'b0;
      end
      if (ctl.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_step_r <= '0;
      ang_step_r <= '0;
      lin_gp_r   <= LIN_GAIN_P_RST;
      lin_gi_r   <= LIN_GAIN_I_RST;
      lin_gk_r   <= LIN_GAIN_K_RST;
      ang_gp_r   <= ANG_GAIN_P_RST;
      ang_gi_r   <= ANG_GAIN_I_RST;
      ang_gk_r   <= ANG_GAIN_K_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIN_RAMP_STEP: lin_step_r <= cfg_data[VALUE_BITS-2:0];
        REG_ANG_RAMP_STEP: ang_step_r <= cfg_data[VALUE_BITS-2:0];
        REG_LIN_GAIN_P:    lin_gp_r   <= cfg_data[GAIN_BITS-1:0];
        REG_LIN_GAIN_I:    lin_gi_r   <= cfg_data[GAIN_BITS-1:0];
        REG_LIN_GAIN_K:    lin_gk_r   <= cfg_data[GAIN_BITS-1:0];
        REG_ANG_GAIN_P:    ang_gp_r   <= cfg_data[GAIN_BITS-1:0];
        REG_ANG_GAIN_I:    ang_gi_r   <= cfg_data[GAIN_BITS-1:0];
        REG_ANG_GAIN_K:    ang_gk_r   <= cfg_data[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  darpc_axis #(
    .VALUE_BITS(VALUE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_lin (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .ramp_step(lin_step_r),
    .gain_p   (lin_gp_r),
    .gain_i   (lin_gi_r),
    .gain_k   (lin_gk_r),
    .measured (in_measured_velocity),
    .load     (in_load_linear_target),
    .target   (in_linear_target),
    .setpoint (out_linear_setpoint),
    .effort   (out_linear_effort)
  );

  darpc_axis #(
    .VALUE_BITS(VALUE_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_ang (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .ramp_step(ang_step_r),
    .gain_p   (ang_gp_r),
    .gain_i   (ang_gi_r),
    .gain_k   (ang_gk_r),
    .measured (in_measured_angular_rate),
    .load     (in_load_angular_target),
    .target   (in_angular_target),
    .setpoint (out_angular_setpoint),
    .effort   (out_angular_effort)
  );

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the output stage is empty");

  a_out_rises_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(v3_r))
    else $error("result appeared without a beat in the last stage");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones({v1_r, v2_r, v3_r, out_valid_r}) ==
       $past($countones({v1_r, v2_r, v3_r, out_valid_r}))
       + $past(in_valid && in_ready) - $past(out_valid && out_ready)))
    else $error("pipeline occupancy does not match accepted and delivered beats");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !v3_r) |=> !out_valid_r)
    else $error("result repeated after delivery");
`endif

endmodule
